[rtl/abe_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// abe_pkg
// Shared types and constants of the allocation bitmap engine.
// ----------------------------------------------------------------------------
package abe_pkg;

  localparam int NUM_BITS  = 1024;
  localparam int WORD_W    = 32;
  localparam int NUM_WORDS = NUM_BITS / WORD_W;
  localparam int WADDR_W   = $clog2(NUM_WORDS);
  localparam int BIT_W     = $clog2(WORD_W);
  localparam int IDX_W     = 10;
  localparam int LEN_W     = 11;
  localparam int OP_W      = 3;
  localparam int CNT_W     = 11;
  localparam int DATA_W    = 32;
  localparam int ADDR_W    = 3;

  localparam logic [ADDR_W-1:0] REG_ACTIVE_ENTRIES = 3'd0;
  localparam logic [CNT_W-1:0]  ACTIVE_RESET       = 11'd1024;
  localparam logic [CNT_W-1:0]  NUM_BITS_CNT       = 11'd1024;

  typedef enum logic [OP_W-1:0] {
    OP_MARK         = 3'd0,
    OP_UNMARK       = 3'd1,
    OP_MARK_RANGE   = 3'd2,
    OP_UNMARK_RANGE = 3'd3,
    OP_TEST         = 3'd4,
    OP_FIND_FREE    = 3'd5,
    OP_FIND_RANGE   = 3'd6,
    OP_NONE         = 3'd7
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_RUN  = 3'b010,
    ST_FIN  = 3'b100
  } state_t;

endpackage

[rtl/allocation_bitmap_engine_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// allocation_bitmap_engine_core
// First-fit bitmap allocator over a word-wide map memory with per-word
// valid bits; marks, ranges, tests and free-bit / free-run searches.
// ----------------------------------------------------------------------------
//  channel | direction | handshake          | payload
//  in_     | input     | in_valid/in_stall  | in_op, in_index, in_length
//  out_    | output    | out_valid/out_stall| out_found, out_result_index,
//          |           |                    | out_bit_set, out_error
//  cfg     | input     | psel/penable/pready| paddr, pwdata, prdata
//
// An item visits one map word per cycle, as the memory port allows, and a full
// scan covers all 32 words.
// Errors and no-op ranges go straight to the finish state without a map read.
// After reset every word reads as all ones through its valid bit; no sweep.
// in_stall is high while an item is in work; one finished result may wait.
// ----------------------------------------------------------------------------
module allocation_bitmap_engine_core
  import abe_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [OP_W-1:0]   in_op,
  input  logic [IDX_W-1:0]  in_index,
  input  logic [LEN_W-1:0]  in_length,
  output logic              out_valid,
  input  logic              out_stall,
  output logic              out_found,
  output logic [IDX_W-1:0]  out_result_index,
  output logic              out_bit_set,
  output logic              out_error,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  // map memory and valid bits
  logic [WORD_W-1:0]    mem [NUM_WORDS];
  logic [NUM_WORDS-1:0] vld_r, vld_nxt;
  logic [WORD_W-1:0]    rdata_r;
  logic                 rvld_r;
  logic                 rd_en;
  logic [WADDR_W-1:0]   rd_addr;
  logic                 wr_en;
  logic [WORD_W-1:0]    wdata;

  state_t             state_r, state_nxt;
  logic [CNT_W-1:0]   active_r;
  op_t                op_r, op_nxt;
  logic [IDX_W-1:0]   idx_r, idx_nxt;
  logic [LEN_W-1:0]   len_r, len_nxt;
  logic [CNT_W-1:0]   n_r, n_nxt;
  logic [IDX_W-1:0]   end_r, end_nxt;
  logic [WADDR_W-1:0] word_r, word_nxt;
  logic [WADDR_W-1:0] last_r, last_nxt;
  logic [CNT_W-1:0]   run_r, run_nxt;
  logic               found_r, found_nxt;
  logic [IDX_W-1:0]   res_r, res_nxt;
  logic               bset_r, bset_nxt;
  logic               err_r, err_nxt;
  logic               out_valid_r;
  logic               out_found_r, out_bset_r, out_err_r;
  logic [IDX_W-1:0]   out_res_r;

  logic               in_xfer;
  logic               cfg_wr;
  logic [CNT_W-1:0]   n_in;
  logic [LEN_W:0]     range_end;
  logic [LEN_W:0]     end_cap;

  // per-word processing
  logic [WORD_W-1:0]  d;
  logic [WORD_W-1:0]  wmask;
  logic [WORD_W-1:0]  occ;
  logic [WORD_W-1:0]  hit;
  logic [WORD_W-1:0]  zfree;
  logic [IDX_W-1:0]   p;
  logic [BIT_W:0]     lastone;
  logic [CNT_W-1:0]   run_j;
  logic [CNT_W-1:0]   run_top;
  logic               any_hit, any_free;
  logic [BIT_W-1:0]   hit_pos, free_pos;
  logic [CNT_W-1:0]   hit_end;
  logic               is_write;

  assign in_xfer  = in_valid && !in_stall;
  assign in_stall = (state_r != ST_IDLE);
  assign pready   = 1'b1;
  assign cfg_wr   = psel && penable && pwrite && pready;
  assign prdata   = (paddr == REG_ACTIVE_ENTRIES) ? {{(DATA_W-CNT_W){1'b0}}, active_r}
                                                  : '0;

  assign out_valid        = out_valid_r;
  assign out_found        = out_found_r;
  assign out_result_index = out_res_r;
  assign out_bit_set      = out_bset_r;
  assign out_error        = out_err_r;

  // configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= ACTIVE_RESET;
    end else if (cfg_wr && paddr == REG_ACTIVE_ENTRIES) begin
      active_r <= pwdata[CNT_W-1:0];
    end
  end

  assign n_in      = (active_r > NUM_BITS_CNT) ? NUM_BITS_CNT : active_r;
  assign range_end = {2'b00, in_index} + {1'b0, in_length} - 12'd1;
  assign end_cap   = (range_end >= {1'b0, n_in}) ? ({1'b0, n_in} - 12'd1) : range_end;

  // per-word bit logic for the word in rdata
  always_comb begin
    d       = rvld_r ? rdata_r : '1;
    wmask   = '0;
    occ     = '0;
    zfree   = '0;
    hit     = '0;
    run_top = '0;
    for (int j = 0; j < WORD_W; j++) begin
      p        = {word_r, j[BIT_W-1:0]};
      wmask[j] = (p >= idx_r) && (p <= end_r);
      occ[j]   = d[j] || ({1'b0, p} >= n_r);
      zfree[j] = !occ[j];
    end
    for (int j = 0; j < WORD_W; j++) begin
      lastone = '0;
      for (int k = 0; k < WORD_W; k++) begin
        if (k <= j && occ[k]) lastone = (BIT_W+1)'(k + 1);
      end
      if (lastone == '0) run_j = run_r + CNT_W'(j + 1);
      else               run_j = CNT_W'(j + 1) - {{(CNT_W-BIT_W-1){1'b0}}, lastone};
      hit[j] = (run_j >= len_r);
      if (j == WORD_W - 1) run_top = run_j;
    end
  end

  // first hit and first free bit
  always_comb begin
    any_hit  = |hit;
    any_free = |zfree;
    hit_pos  = '0;
    free_pos = '0;
    for (int j = WORD_W - 1; j >= 0; j--) begin
      if (hit[j])   hit_pos  = j[BIT_W-1:0];
      if (zfree[j]) free_pos = j[BIT_W-1:0];
    end
    hit_end  = {1'b0, word_r, hit_pos} + 11'd1 - len_r;
  end

  assign is_write = (op_r == OP_MARK) || (op_r == OP_UNMARK) ||
                    (op_r == OP_MARK_RANGE) || (op_r == OP_UNMARK_RANGE);

  // sequencer
  always_comb begin
    state_nxt = state_r;
    op_nxt    = op_r;
    idx_nxt   = idx_r;
    len_nxt   = len_r;
    n_nxt     = n_r;
    end_nxt   = end_r;
    word_nxt  = word_r;
    last_nxt  = last_r;
    run_nxt   = run_r;
    found_nxt = found_r;
    res_nxt   = res_r;
    bset_nxt  = bset_r;
    err_nxt   = err_r;
    rd_en     = 1'b0;
    rd_addr   = word_r;
    wr_en     = 1'b0;
    wdata     = d;
    unique case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          op_nxt    = op_t'(in_op);
          idx_nxt   = in_index;
          n_nxt     = n_in;
          run_nxt   = '0;
          found_nxt = 1'b0;
          res_nxt   = '0;
          bset_nxt  = 1'b0;
          err_nxt   = 1'b0;
          end_nxt   = end_cap[IDX_W-1:0];
          len_nxt   = in_length;
          word_nxt  = in_index[IDX_W-1:BIT_W];
          last_nxt  = end_cap[IDX_W-1:BIT_W];
          state_nxt = ST_RUN;
          rd_en     = 1'b1;
          rd_addr   = in_index[IDX_W-1:BIT_W];
          unique case (op_t'(in_op))
            OP_MARK, OP_UNMARK, OP_TEST: begin
              len_nxt  = 11'd1;
              end_nxt  = in_index;
              last_nxt = in_index[IDX_W-1:BIT_W];
              if ({1'b0, in_index} >= n_in) begin
                state_nxt = ST_FIN;
                rd_en     = 1'b0;
              end
            end
            OP_MARK_RANGE, OP_UNMARK_RANGE: begin
              if (in_length == '0 || {1'b0, in_index} >= n_in) begin
                state_nxt = ST_FIN;
                rd_en     = 1'b0;
              end
            end
            OP_FIND_FREE, OP_FIND_RANGE: begin
              word_nxt = '0;
              rd_addr  = '0;
              last_nxt = n_in[IDX_W-1:BIT_W] - WADDR_W'(n_in[BIT_W-1:0] == '0);
              if (op_t'(in_op) == OP_FIND_RANGE &&
                  (in_length == '0 || in_length >= n_in)) begin
                err_nxt   = 1'b1;
                state_nxt = ST_FIN;
                rd_en     = 1'b0;
              end else if (n_in == '0) begin
                state_nxt = ST_FIN;
                rd_en     = 1'b0;
              end
            end
            default: begin
              state_nxt = ST_FIN;
              rd_en     = 1'b0;
            end
          endcase
        end
      end
      ST_RUN: begin
        priority if (is_write) begin
          wr_en = 1'b1;
          if (op_r == OP_MARK || op_r == OP_MARK_RANGE) wdata = d | wmask;
          else                                          wdata = d & ~wmask;
          if (word_r == last_r) state_nxt = ST_FIN;
        end else if (op_r == OP_TEST) begin
          bset_nxt  = d[idx_r[BIT_W-1:0]];
          state_nxt = ST_FIN;
        end else if (op_r == OP_FIND_FREE) begin
          if (any_free) begin
            found_nxt = 1'b1;
            res_nxt   = {word_r, free_pos};
            state_nxt = ST_FIN;
          end else if (word_r == last_r) begin
            state_nxt = ST_FIN;
          end
        end else begin
          run_nxt = run_top;
          if (any_hit) begin
            found_nxt = 1'b1;
            res_nxt   = hit_end[IDX_W-1:0];
            state_nxt = ST_FIN;
          end else if (word_r == last_r) begin
            state_nxt = ST_FIN;
          end
        end
        if (state_nxt == ST_RUN) begin
          word_nxt = word_r + 1'b1;
          rd_en    = 1'b1;
          rd_addr  = word_r + 1'b1;
        end
      end
      ST_FIN: begin
        if (!out_valid_r || !out_stall) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // memory port: one read, one write per cycle
  always_ff @(posedge clk) begin
    if (wr_en) mem[word_r] <= wdata;
    if (rd_en) begin
      rdata_r <= mem[rd_addr];
      rvld_r  <= vld_nxt[rd_addr] && vld_r[rd_addr];
    end
  end

  always_comb begin
    vld_nxt = vld_r;
    if (wr_en) vld_nxt[word_r] = 1'b1;
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      vld_r   <= vld_nxt;
      if (state_r == ST_FIN && (!out_valid_r || !out_stall)) out_valid_r <= 1'b1;
      else if (!out_stall)                                   out_valid_r <= 1'b0;
    end
  end

  // item and result registers
  always_ff @(posedge clk) begin
    op_r    <= op_nxt;
    idx_r   <= idx_nxt;
    len_r   <= len_nxt;
    n_r     <= n_nxt;
    end_r   <= end_nxt;
    word_r  <= word_nxt;
    last_r  <= last_nxt;
    run_r   <= run_nxt;
    found_r <= found_nxt;
    res_r   <= res_nxt;
    bset_r  <= bset_nxt;
    err_r   <= err_nxt;
    if (state_r == ST_FIN && (!out_valid_r || !out_stall)) begin
      out_found_r <= found_r;
      out_res_r   <= res_r;
      out_bset_r  <= bset_r;
      out_err_r   <= err_r;
    end
  end

`ifndef SYNTHESIS
  a_state_onehot: assert property (@(posedge clk) disable iff (!rst_n) $onehot(state_r))
    else $error("sequencer state not one-hot");
  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> state_r != ST_IDLE)
    else $error("accepted transfer did not start work");
  a_write_in_run: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> state_r == ST_RUN)
    else $error("map write outside of run");
`endif

endmodule

[verif/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Checks the allocation bitmap engine against a cycle-free model of the
// bitmap: marks, ranges, tests and first-fit searches under several entry
// counts, with random sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module testbench;
  import abe_pkg::*;

  localparam int CYCLE_LIMIT = 600000;

  // one result of the allocator
  typedef struct packed {
    logic             found;
    logic [IDX_W-1:0] result_index;
    logic             bit_set;
    logic             error;
  } alloc_result_t;

  // bitmap model and queue of pending allocator results
  class alloc_scoreboard;
    bit            map_bits[NUM_BITS];
    logic [CNT_W-1:0] active_entries;
    alloc_result_t expected_q[$];
    int            mismatches;
    int            inputs_seen;
    int            results_seen;

    function new();
      foreach (map_bits[i]) map_bits[i] = 1'b1;
      active_entries = ACTIVE_RESET;
      mismatches = 0;
      inputs_seen = 0;
      results_seen = 0;
    endfunction

    function int entries_in_use();
      return (active_entries > NUM_BITS_CNT) ? NUM_BITS : int'(active_entries);
    endfunction

    function void set_active(logic [CNT_W-1:0] value);
      active_entries = value;
    endfunction

    function void write_mark(int pos, bit value);
      if (pos < entries_in_use()) map_bits[pos] = value;
    endfunction

    // apply one transfer to the map and queue the result it causes
    function void note_input(op_t op, logic [IDX_W-1:0] idx, logic [LEN_W-1:0] len);
      alloc_result_t r;
      int n;
      int run;
      r = '0;
      n = entries_in_use();
      inputs_seen++;
      case (op)
        OP_MARK:   write_mark(int'(idx), 1'b1);
        OP_UNMARK: write_mark(int'(idx), 1'b0);
        OP_MARK_RANGE, OP_UNMARK_RANGE: begin
          for (int i = 0; i < int'(len); i++)
            write_mark(int'(idx) + i, op == OP_MARK_RANGE);
        end
        OP_TEST: r.bit_set = (int'(idx) < n) ? map_bits[idx] : 1'b0;
        OP_FIND_FREE: begin
          for (int i = 0; i < n; i++) begin
            if (!map_bits[i]) begin
              r.found = 1'b1;
              r.result_index = i[IDX_W-1:0];
              break;
            end
          end
        end
        OP_FIND_RANGE: begin
          if (len == 0 || int'(len) >= n) begin
            r.error = 1'b1;
          end else begin
            run = 0;
            for (int i = 0; i < n; i++) begin
              if (map_bits[i]) begin
                run = 0;
              end else begin
                run++;
                if (run == int'(len)) begin
                  r.found = 1'b1;
                  r.result_index = IDX_W'(i + 1 - int'(len));
                  break;
                end
              end
            end
          end
        end
        default: ;
      endcase
      expected_q.push_back(r);
    endfunction

    // compare one result transfer with the oldest expectation
    function void check_result(alloc_result_t got);
      alloc_result_t exp_r;
      results_seen++;
      if (expected_q.size() == 0) begin
        $error("result transfer with nothing expected");
        mismatches++;
        return;
      end
      exp_r = expected_q.pop_front();
      if (got.found !== exp_r.found) begin
        $error("found: expected %0d, got %0d", exp_r.found, got.found);
        mismatches++;
      end
      if (got.result_index !== exp_r.result_index) begin
        $error("result_index: expected %0d, got %0d", exp_r.result_index,
               got.result_index);
        mismatches++;
      end
      if (got.bit_set !== exp_r.bit_set) begin
        $error("bit_set: expected %0d, got %0d", exp_r.bit_set, got.bit_set);
        mismatches++;
      end
      if (got.error !== exp_r.error) begin
        $error("error: expected %0d, got %0d", exp_r.error, got.error);
        mismatches++;
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_stall;
  logic [OP_W-1:0]   in_op;
  logic [IDX_W-1:0]  in_index;
  logic [LEN_W-1:0]  in_length;
  logic              out_valid;
  logic              out_stall;
  logic              out_found;
  logic [IDX_W-1:0]  out_result_index;
  logic              out_bit_set;
  logic              out_error;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  alloc_scoreboard sb;
  int  cycle_count;
  int  burst_left;
  bit  stall_enable;
  int  configs_done;

  allocation_bitmap_engine_core u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_op            (in_op),
    .in_index         (in_index),
    .in_length        (in_length),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_found        (out_found),
    .out_result_index (out_result_index),
    .out_bit_set      (out_bit_set),
    .out_error        (out_error),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  // clock
  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // run limit
  initial cycle_count = 0;
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // receiver stall pattern: quiet stretches and stretches of heavy stalling
  always @(negedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if ($urandom_range(0, 99) == 0) stall_enable = ~stall_enable;
      out_stall <= stall_enable && ($urandom_range(0, 3) != 0);
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      sb.check_result('{out_found, out_result_index, out_bit_set, out_error});
  end

  // one input transfer, held until accepted
  task automatic send_item(op_t op, logic [IDX_W-1:0] idx, logic [LEN_W-1:0] len);
    @(negedge clk);
    in_valid  <= 1'b1;
    in_op     <= op;
    in_index  <= idx;
    in_length <= len;
    do @(posedge clk); while (in_stall);
    sb.note_input(op, idx, len);
  endtask

  task automatic idle_cycles(int n);
    @(negedge clk);
    in_valid <= 1'b0;
    repeat (n - 1) @(negedge clk);
  endtask

  // sender bursts separated by random gaps
  task automatic paced_send(op_t op, logic [IDX_W-1:0] idx, logic [LEN_W-1:0] len);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      if ($urandom_range(0, 2) != 0) idle_cycles($urandom_range(1, 8));
    end
    burst_left--;
    send_item(op, idx, len);
  endtask

  task automatic wait_drained();
    idle_cycles(1);
    while (sb.pending() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_active_entries(logic [CNT_W-1:0] value);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= REG_ACTIVE_ENTRIES;
    pwdata  <= DATA_W'(value);
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    sb.set_active(value);
    configs_done++;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // random transfer, biased toward short ranges near the bits in use
  task automatic random_item();
    op_t op;
    logic [IDX_W-1:0] idx;
    logic [LEN_W-1:0] len;
    int pick;
    int n;
    n = sb.entries_in_use();
    pick = $urandom_range(0, 99);
    if (pick < 10)      op = OP_MARK;
    else if (pick < 20) op = OP_UNMARK;
    else if (pick < 30) op = OP_MARK_RANGE;
    else if (pick < 45) op = OP_UNMARK_RANGE;
    else if (pick < 60) op = OP_TEST;
    else if (pick < 75) op = OP_FIND_FREE;
    else if (pick < 96) op = OP_FIND_RANGE;
    else                op = OP_NONE;
    if (n > 0 && $urandom_range(0, 4) != 0) idx = IDX_W'($urandom_range(0, n - 1));
    else idx = IDX_W'($urandom_range(0, NUM_BITS - 1));
    pick = $urandom_range(0, 19);
    if (pick < 14)      len = LEN_W'($urandom_range(0, 24));
    else if (pick < 18) len = LEN_W'($urandom_range(0, 1024));
    else if (pick < 19) len = LEN_W'(1024);
    else                len = LEN_W'(n > 0 ? n - 1 : 0);
    paced_send(op, idx, len);
  endtask

  initial begin
    logic [CNT_W-1:0] phase_cfg[6];
    sb = new();
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_op = OP_NONE;
    in_index = '0;
    in_length = '0;
    out_stall = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    burst_left = 0;
    stall_enable = 1'b0;
    configs_done = 0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: extremes and special cases at the reset entry count
    send_item(OP_TEST, 0, 0);
    send_item(OP_TEST, 1023, 0);
    send_item(OP_FIND_FREE, 0, 0);
    send_item(OP_FIND_RANGE, 0, 0);
    send_item(OP_FIND_RANGE, 0, 1024);
    send_item(OP_FIND_RANGE, 0, 1023);
    send_item(OP_UNMARK, 5, 0);
    send_item(OP_FIND_FREE, 0, 0);
    send_item(OP_UNMARK_RANGE, 100, 20);
    send_item(OP_FIND_RANGE, 0, 10);
    send_item(OP_UNMARK_RANGE, 1000, 1024);
    send_item(OP_FIND_RANGE, 0, 24);
    send_item(OP_TEST, 1023, 2047);
    send_item(OP_NONE, 1023, 2047);
    send_item(OP_MARK_RANGE, 0, 1024);
    send_item(OP_FIND_FREE, 0, 0);
    send_item(OP_UNMARK, 1023, 0);
    send_item(OP_FIND_FREE, 0, 0);
    send_item(OP_FIND_RANGE, 0, 1);
    send_item(OP_MARK, 1023, 0);
    send_item(OP_UNMARK_RANGE, 0, 1024);
    send_item(OP_FIND_RANGE, 0, 1023);
    send_item(OP_MARK_RANGE, 0, 1024);
    wait_drained();

    // random phases at several entry counts, the extremes among them
    phase_cfg = '{11'd8, 11'd2047, 11'd0, 11'd100, 11'd1024, 11'd8};
    phase_cfg[3] = CNT_W'($urandom_range(9, 1023));
    for (int p = 0; p < 7; p++) begin
      if (p > 0) write_active_entries(phase_cfg[p - 1]);
      for (int k = 0; k < 70; k++) begin
        random_item();
        // hold the sender once until everything has come back
        if (p == 1 && k == 35) begin
          idle_cycles(1);
          while (sb.pending() != 0) @(posedge clk);
        end
      end
      wait_drained();
    end

    $display("covered %0d transfers in, %0d results out, %0d register writes",
             sb.inputs_seen, sb.results_seen, configs_done);
    $display("entry counts from zero through saturated, all ops and range errors");
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("end of test: clean");
    end else begin
      if (sb.pending() != 0) $error("%0d expected results never came", sb.pending());
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
